[src/hid_report_size_parser_top_assert.svh]
// Assertion macros for the parser top RTL.
`ifndef HID_REPORT_SIZE_PARSER_TOP_ASSERT_SVH
`define HID_REPORT_SIZE_PARSER_TOP_ASSERT_SVH

// Clocked assertion, checked outside reset.
`define HIDRSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication, with the property checked in the next cycle.
`define HIDRSP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

[src/hidrsp_pkg.sv]
`default_nettype none

package hidrsp_pkg;

  // Short item prefix fields
  localparam logic [1:0] TYPE_MAIN        = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL      = 2'd1;
  localparam logic [3:0] TAG_INPUT        = 4'd8;
  localparam logic [3:0] TAG_OUTPUT       = 4'd9;
  localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;
  localparam logic [1:0] SIZE_CODE_FOUR   = 2'd3;

  localparam int unsigned COUNT_W = 32;
  localparam int unsigned RSIZE_W = 11;

  // Supported report sizes
  localparam logic [COUNT_W-1:0] RSIZE_64   = 32'd64;
  localparam logic [COUNT_W-1:0] RSIZE_512  = 32'd512;
  localparam logic [COUNT_W-1:0] RSIZE_1024 = 32'd1024;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_MISMATCH    = 2'd1,
    STATUS_UNSUPPORTED = 2'd2
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [RSIZE_W-1:0]   size;
  } result_t;

endpackage

`default_nettype wire

[src/hidrsp_judge.sv]
`default_nettype none

module hidrsp_judge (
  input  wire logic [hidrsp_pkg::COUNT_W-1:0] input_size,
  input  wire logic [hidrsp_pkg::COUNT_W-1:0] output_size,
  output hidrsp_pkg::result_t                 result
);
  import hidrsp_pkg::*;

  logic supported;

  assign supported = (input_size == RSIZE_64) || (input_size == RSIZE_512) ||
                     (input_size == RSIZE_1024);

  always_comb begin
    if (input_size != output_size) begin
      result.status = STATUS_MISMATCH;
      result.size   = '0;
    end else if (supported) begin
      result.status = STATUS_OK;
      result.size   = input_size[RSIZE_W-1:0];
    end else begin
      result.status = STATUS_UNSUPPORTED;
      result.size   = '0;
    end
  end

endmodule

`default_nettype wire

[src/hid_report_size_parser_top.sv]
// Channel   | Direction | Signals                        | Transfer when
// ----------+-----------+--------------------------------+-----------------------
// in        | input     | in_valid, in_stall, desc_byte, | in_valid && !in_stall
//           |           | last_byte                      |
// out       | output    | out_valid, out_stall, status,  | out_valid && !out_stall
//           |           | rpt_size                       |
//
// One descriptor byte per cycle while in_stall is low; the item state updates
// on the transfer edge. The verdict sits in the result register in the cycle
// after the last byte; a compare of the sizes as that byte leaves them sets it.
// Synchronous active-high reset clears the item state and empties the output.
// in_stall is raised only while a verdict sits in the output register and the
// sink stalls it; non-final bytes are held back too in that case.
`default_nettype none

module hid_report_size_parser_top (
  input  wire logic       clk,
  input  wire logic       rst,
  // descriptor byte stream
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] desc_byte,
  input  wire logic       last_byte,
  // verdict
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      status,
  output logic [hidrsp_pkg::RSIZE_W-1:0] rpt_size
);
  import hidrsp_pkg::*;

  // Parser state
  logic [COUNT_W-1:0] running_count, running_count_next;
  logic [COUNT_W-1:0] input_size,    input_size_next;
  logic [COUNT_W-1:0] output_size,   output_size_next;
  logic [2:0]         bytes_left,    bytes_left_next;
  logic [1:0]         byte_position, byte_position_next;
  logic               gathering_count, gathering_count_next;

  // State after this byte, before the end-of-descriptor clear
  logic [COUNT_W-1:0] running_count_upd, input_size_upd, output_size_upd;
  logic [2:0]         bytes_left_upd;
  logic [1:0]         byte_position_upd;
  logic               gathering_count_upd;

  logic [3:0] pfx_tag;
  logic [1:0] pfx_type;
  logic [1:0] pfx_code;
  logic       in_xfer;
  logic       end_xfer;

  result_t verdict;
  result_t result;

  // Output register drains or is empty: room for a byte.
  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign end_xfer = in_xfer && last_byte;

  assign pfx_tag  = desc_byte[7:4];
  assign pfx_type = desc_byte[3:2];
  assign pfx_code = desc_byte[1:0];

  always_comb begin
    running_count_upd   = running_count;
    input_size_upd      = input_size;
    output_size_upd     = output_size;
    bytes_left_upd      = bytes_left;
    byte_position_upd   = byte_position;
    gathering_count_upd = gathering_count;

    if (bytes_left == 3'd0) begin
      // prefix byte: Main items latch here, Report Count restarts the count
      gathering_count_upd = 1'b0;
      if (pfx_type == TYPE_GLOBAL && pfx_tag == TAG_REPORT_COUNT) begin
        running_count_upd   = '0;
        gathering_count_upd = 1'b1;
      end else if (pfx_type == TYPE_MAIN && pfx_tag == TAG_INPUT) begin
        input_size_upd = running_count;
      end else if (pfx_type == TYPE_MAIN && pfx_tag == TAG_OUTPUT) begin
        output_size_upd = running_count;
      end
      bytes_left_upd    = (pfx_code == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, pfx_code};
      byte_position_upd = 2'd0;
    end else begin
      // data byte, little-endian into the count
      if (gathering_count) begin
        running_count_upd = running_count |
                            (COUNT_W'(desc_byte) << {byte_position, 3'b000});
      end
      byte_position_upd = byte_position + 2'd1;
      bytes_left_upd    = bytes_left - 3'd1;
    end
  end

  always_comb begin
    running_count_next   = running_count;
    input_size_next      = input_size;
    output_size_next     = output_size;
    bytes_left_next      = bytes_left;
    byte_position_next   = byte_position;
    gathering_count_next = gathering_count;
    if (end_xfer) begin
      // descriptor done: back to reset state
      running_count_next   = '0;
      input_size_next      = '0;
      output_size_next     = '0;
      bytes_left_next      = 3'd0;
      byte_position_next   = 2'd0;
      gathering_count_next = 1'b0;
    end else if (in_xfer) begin
      running_count_next   = running_count_upd;
      input_size_next      = input_size_upd;
      output_size_next     = output_size_upd;
      bytes_left_next      = bytes_left_upd;
      byte_position_next   = byte_position_upd;
      gathering_count_next = gathering_count_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_count   <= '0;
      input_size      <= '0;
      output_size     <= '0;
      bytes_left      <= 3'd0;
      byte_position   <= 2'd0;
      gathering_count <= 1'b0;
    end else begin
      running_count   <= running_count_next;
      input_size      <= input_size_next;
      output_size     <= output_size_next;
      bytes_left      <= bytes_left_next;
      byte_position   <= byte_position_next;
      gathering_count <= gathering_count_next;
    end
  end

  // Judge the sizes as they stand after the final byte.
  hidrsp_judge u_judge (
    .input_size  (input_size_upd),
    .output_size (output_size_upd),
    .result      (verdict)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (end_xfer) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_xfer) begin
      result <= verdict;
    end
  end

  assign status   = result.status;
  assign rpt_size = result.size;

  `include "hid_report_size_parser_top_assert.svh"

  `HIDRSP_ASSERT(a_size_only_when_ok,
    !(out_valid && result.status != STATUS_OK) || result.size == '0,
    "report size set on a failing verdict")

  `HIDRSP_ASSERT(a_ok_size_supported,
    !(out_valid && result.status == STATUS_OK) ||
    (result.size == 11'd64 || result.size == 11'd512 || result.size == 11'd1024),
    "ok verdict with an unsupported size")

  `HIDRSP_ASSERT_NEXT(a_end_gives_result, end_xfer, out_valid,
    "final byte produced no verdict")

  `HIDRSP_ASSERT_NEXT(a_end_clears_state, end_xfer,
    bytes_left == 3'd0 && running_count == '0 && input_size == '0 &&
    output_size == '0 && !gathering_count,
    "state not cleared after final byte")

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for the HID report descriptor size parser.
//
// The descriptor stream goes in one byte per transfer. A byte with last_byte
// set closes the descriptor, and one verdict (status, rpt_size) follows.
// The bench keeps its own copy of the parser state. It advances that copy on
// every accepted byte and queues the expected verdict on the last byte. The
// checker process pops the oldest verdict on each output transfer and
// compares it field by field.
module tb_top;
  import hidrsp_pkg::*;

  localparam logic [7:0]  LONG_ITEM_PREFIX = 8'hFE;
  localparam int unsigned RANDOM_BYTES     = 1000;
  localparam int unsigned DRAIN_LIMIT      = 5000;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [7:0]          desc_byte = 8'h00;
  logic                last_byte = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          status;
  logic [RSIZE_W-1:0]  rpt_size;

  hid_report_size_parser_top DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .desc_byte   (desc_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .rpt_size    (rpt_size)
  );

  always #1 clk = ~clk;

  // Shadow of the parser state, advanced on each accepted byte.
  logic [COUNT_W-1:0] run_count;
  logic [COUNT_W-1:0] in_size;
  logic [COUNT_W-1:0] out_size;
  logic [2:0]         bytes_due;   // data bytes still owed by the current item
  logic [1:0]         data_pos;    // next data byte index within the item
  logic               count_open;  // current item is a Report Count

  result_t     verdict_q[$];   // verdicts still owed by the parser
  bit [7:0]    desc_bytes[$];  // descriptor being assembled for sending
  bit          no_idle;        // suppress gaps and stalls on both sides
  int unsigned hold_cnt;
  int unsigned err_count;
  int unsigned byte_count;
  int unsigned verdict_count;
  int unsigned ok_count;
  int unsigned mismatch_count;
  int unsigned unsup_count;

  task automatic clear_parser();
    run_count  = '0;
    in_size    = '0;
    out_size   = '0;
    bytes_due  = '0;
    data_pos   = '0;
    count_open = 1'b0;
  endtask

  // One byte through the shadow parser; queues a verdict on the last byte.
  task automatic parse_desc_byte(input logic [7:0] b, input logic is_last);
    logic [3:0] tag;
    logic [1:0] item_type;
    logic [1:0] code;
    result_t    v;
    if (bytes_due == 0) begin
      tag        = b[7:4];
      item_type  = b[3:2];
      code       = b[1:0];
      count_open = 1'b0;
      if (item_type == TYPE_GLOBAL && tag == TAG_REPORT_COUNT) begin
        run_count  = '0;
        count_open = 1'b1;
      end else if (item_type == TYPE_MAIN && tag == TAG_INPUT) begin
        in_size = run_count;
      end else if (item_type == TYPE_MAIN && tag == TAG_OUTPUT) begin
        out_size = run_count;
      end
      bytes_due = (code == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, code};
      data_pos  = '0;
    end else begin
      // little-endian gather, only for Report Count
      if (count_open)
        run_count[8*data_pos +: 8] = run_count[8*data_pos +: 8] | b;
      data_pos  = data_pos + 2'd1;
      bytes_due = bytes_due - 3'd1;
    end
    if (is_last) begin
      if (in_size != out_size) begin
        v.status = STATUS_MISMATCH;
        v.size   = '0;
      end else if (in_size == RSIZE_64 || in_size == RSIZE_512 || in_size == RSIZE_1024) begin
        v.status = STATUS_OK;
        v.size   = in_size[RSIZE_W-1:0];
      end else begin
        v.status = STATUS_UNSUPPORTED;
        v.size   = '0;
      end
      verdict_q.push_back(v);
      clear_parser();
    end
  endtask

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 10) return 0;
    else if (r < 14) return $urandom_range(1, 3);
    else if (r == 14) return $urandom_range(4, 8);
    else return $urandom_range(10, 30);
  endfunction

  // Send one byte; returns in the step of its transfer, valid still high.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    gap = no_idle ? 0 : idle_len();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    desc_byte <= b;
    last_byte <= is_last;
    do @(posedge clk); while (in_stall);
    parse_desc_byte(b, is_last);
    byte_count++;
  endtask

  // Prefix plus the data bytes its size code calls for.
  task automatic add_item(input logic [7:0] prefix, input logic [31:0] data);
    int unsigned n;
    n = (prefix[1:0] == SIZE_CODE_FOUR) ? 4 : prefix[1:0];
    desc_bytes.push_back(prefix);
    for (int i = 0; i < n; i++) desc_bytes.push_back(data[8*i +: 8]);
  endtask

  // keep = 0 sends the whole descriptor, otherwise it is cut after keep bytes.
  task automatic send_descriptor(input int unsigned keep);
    int unsigned n;
    n = (keep == 0 || keep > desc_bytes.size()) ? desc_bytes.size() : keep;
    for (int i = 0; i < n; i++) send_byte(desc_bytes[i], i == n - 1);
    desc_bytes.delete();
  endtask

  // Hold the sender off until every verdict is in or the drain limit is reached.
  task automatic wait_for_verdicts();
    int unsigned n;
    n = 0;
    in_valid <= 1'b0;
    while (verdict_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1:    return RSIZE_64;
      2:       return RSIZE_512;
      3:       return RSIZE_1024;
      4:       return $urandom_range(0, 255);
      5:       return $urandom_range(0, 2047);
      6:       return $urandom();
      7:       return RSIZE_64 | (32'd1 << $urandom_range(11, 31));  // aliases 64 in 11 bits
      8:       return '0;
      default: return $urandom_range(0, 1) ? RSIZE_1024 + 32'd1 : RSIZE_1024 - 32'd1;
    endcase
  endfunction

  task automatic add_report_count(input logic [31:0] value);
    logic [1:0] min_code;
    logic [1:0] code;
    if (value == 0)          min_code = 2'd0;
    else if (value < 256)    min_code = 2'd1;
    else if (value < 65536)  min_code = 2'd2;
    else                     min_code = SIZE_CODE_FOUR;
    code = 2'($urandom_range(min_code, SIZE_CODE_FOUR));
    // now and then a random size code, which may be too short for the value
    if ($urandom_range(0, 7) == 0) code = 2'($urandom_range(0, 3));
    add_item({TAG_REPORT_COUNT, TYPE_GLOBAL, code}, value);
  endtask

  task automatic add_main(input logic [3:0] tag);
    logic [1:0] code;
    code = 2'($urandom_range(0, 3));
    add_item({tag, TYPE_MAIN, code}, $urandom());
  endtask

  task automatic add_noise();
    logic [7:0] prefix;
    prefix = ($urandom_range(0, 7) == 0) ? LONG_ITEM_PREFIX : 8'($urandom_range(0, 255));
    add_item(prefix, $urandom());
  endtask

  // Mostly count / input / output descriptors with random content, some cut
  // short; the rest are shuffled items or raw byte noise.
  task automatic build_random_descriptor(output int unsigned keep);
    int unsigned shape;
    logic [31:0] cnt;
    shape = $urandom_range(0, 9);
    keep  = 0;
    if (shape <= 5 || shape == 9) begin
      if ($urandom_range(0, 2) == 0) add_noise();
      cnt = pick_count();
      add_report_count(cnt);
      if ($urandom_range(0, 3) == 0) add_noise();
      if ($urandom_range(0, 1) == 0) begin
        add_main(TAG_INPUT);
        if ($urandom_range(0, 3) == 0) add_report_count($urandom_range(0, 1) ? pick_count() : cnt);
        add_main(TAG_OUTPUT);
      end else begin
        add_main(TAG_OUTPUT);
        if ($urandom_range(0, 3) == 0) add_report_count($urandom_range(0, 1) ? pick_count() : cnt);
        add_main(TAG_INPUT);
      end
      if ($urandom_range(0, 3) == 0) add_noise();
      if (shape == 9) keep = $urandom_range(1, desc_bytes.size());
    end else if (shape <= 7) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0:       add_report_count(pick_count());
          1:       add_main(TAG_INPUT);
          2:       add_main(TAG_OUTPUT);
          default: add_noise();
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 8)) desc_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // 64, 512 and 1024 with one, two and four count bytes.
  task automatic test_supported_sizes();
    add_item({TAG_REPORT_COUNT, TYPE_GLOBAL, 2'd1}, RSIZE_64);
    add_item({TAG_INPUT, TYPE_MAIN, 2'd0}, '0);
    add_item({TAG_OUTPUT, TYPE_MAIN, 2'd0}, '0);
    send_descriptor(0);
    // data bytes of main items are skipped: all-ones and all-zeros here
    add_item({TAG_REPORT_COUNT, TYPE_GLOBAL, 2'd2}, RSIZE_512);
    add_item({TAG_INPUT, TYPE_MAIN, 2'd1}, 32'hFF);
    add_item({TAG_OUTPUT, TYPE_MAIN, 2'd1}, 32'h00);
    send_descriptor(0);
    add_item({TAG_REPORT_COUNT, TYPE_GLOBAL, SIZE_CODE_FOUR}, RSIZE_1024);
    add_item({TAG_INPUT, TYPE_MAIN, 2'd0}, '0);
    add_item({TAG_OUTPUT, TYPE_MAIN, 2'd0}, '0);
    send_descriptor(0);
    wait_for_verdicts();
  endtask

  // Long-item prefix skipped as a short item, then a count cut off part
  // way through its data: output never latches, so the sizes differ.
  task automatic test_mismatch_and_skips();
    add_item(LONG_ITEM_PREFIX, 32'h3412);
    add_item({TAG_REPORT_COUNT, TYPE_GLOBAL, 2'd1}, 32'd8);
    add_item({TAG_INPUT, TYPE_MAIN, 2'd0}, '0);
    add_item({TAG_REPORT_COUNT, TYPE_GLOBAL, SIZE_CODE_FOUR}, RSIZE_64);
    send_descriptor(desc_bytes.size() - 2);
    wait_for_verdicts();
  endtask

  // Both sizes zero (main item latching on its final prefix byte), and a
  // count whose low eleven bits read as 64 but with a higher bit set.
  task automatic test_unsupported_sizes();
    add_item({TAG_INPUT, TYPE_MAIN, 2'd0}, '0);
    send_descriptor(0);
    add_item({TAG_REPORT_COUNT, TYPE_GLOBAL, SIZE_CODE_FOUR}, 32'h0001_0040);
    add_item({TAG_INPUT, TYPE_MAIN, 2'd0}, '0);
    add_item({TAG_OUTPUT, TYPE_MAIN, 2'd0}, '0);
    send_descriptor(0);
    wait_for_verdicts();
  endtask

  task automatic test_random_descriptors();
    int unsigned keep;
    int unsigned stop_at;
    stop_at = byte_count + RANDOM_BYTES;
    while (byte_count < stop_at) begin
      build_random_descriptor(keep);
      send_descriptor(keep);
      // occasionally let the output side run dry before going on
      if ($urandom_range(0, 19) == 0) wait_for_verdicts();
    end
    wait_for_verdicts();
  endtask

  // Full rate on both sides: verdicts leave while the next descriptor streams.
  task automatic test_back_to_back();
    int unsigned keep;
    no_idle = 1'b1;
    repeat (10) begin
      build_random_descriptor(keep);
      send_descriptor(keep);
    end
    wait_for_verdicts();
    no_idle = 1'b0;
  endtask

  // ------------------------------------------------------------- sink side

  // Random stall with held lengths; off during reset and full-rate stretches.
  always @(posedge clk) begin
    if (rst || no_idle) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_stall <= 1'($urandom_range(0, 1));
      hold_cnt  <= idle_len();
    end
  end

  // Each output transfer against the oldest owed verdict.
  always @(posedge clk) begin : check_verdict
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict: status %0d, rpt_size %0d", status, rpt_size);
        err_count++;
      end else begin
        want = verdict_q.pop_front();
        verdict_count++;
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          err_count++;
        end
        if (rpt_size !== want.size) begin
          $error("rpt_size: expected %0d, got %0d", want.size, rpt_size);
          err_count++;
        end
        case (want.status)
          STATUS_OK:       ok_count++;
          STATUS_MISMATCH: mismatch_count++;
          default:         unsup_count++;
        endcase
      end
    end
  end

  // --------------------------------------------------------------- sequence

  initial begin
    clear_parser();
    no_idle = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_supported_sizes();
    test_mismatch_and_skips();
    test_unsupported_sizes();
    test_random_descriptors();
    test_back_to_back();

    wait_for_verdicts();
    if (verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", verdict_q.size());
      err_count += verdict_q.size();
    end
    $display("tb_top: %0d descriptor bytes sent, %0d verdicts checked", byte_count,
             verdict_count);
    $display("tb_top: verdicts ok %0d, size mismatch %0d, unsupported %0d", ok_count,
             mismatch_count, unsup_count);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/hidrsp_pkg.sv
src/hidrsp_judge.sv
src/hid_report_size_parser_top.sv
test/tb_top.sv
